@@ rtl/ipv4rhc_pkg.sv @@
// Shared types, constants and helpers for the IPv4 receive header checker.
// No dependencies; compiled first.
package ipv4rhc_pkg;

    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [15:0] COUNT_MAX     = 16'hFFFF;
    localparam logic [15:0] MIN_HDR_BYTES = 16'd20;
    localparam logic [3:0]  IPV4_VERSION  = 4'd4;
    localparam logic [7:0]  PROTO_ICMP    = 8'd1;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;
    localparam logic [15:0] FRAG_MASK     = 16'h3FFF;
    localparam logic [31:0] BCAST_ADDR    = 32'hFFFFFFFF;

    localparam logic [15:0] POS_VER_IHL   = 16'd0;
    localparam logic [15:0] POS_TLEN_HI   = 16'd2;
    localparam logic [15:0] POS_TLEN_LO   = 16'd3;
    localparam logic [15:0] POS_FRAG_HI   = 16'd6;
    localparam logic [15:0] POS_FRAG_LO   = 16'd7;
    localparam logic [15:0] POS_PROTO     = 16'd9;
    localparam logic [15:0] POS_CSUM_HI   = 16'd10;
    localparam logic [15:0] POS_CSUM_LO   = 16'd11;
    localparam logic [15:0] POS_SRC_FIRST = 16'd12;
    localparam logic [15:0] POS_SRC_LAST  = 16'd15;
    localparam logic [15:0] POS_DST_FIRST = 16'd16;
    localparam logic [15:0] POS_DST_LAST  = 16'd19;

    typedef enum logic {
        CFG_LOCAL_ADDR  = 1'b0,
        CFG_ADDR_VALID  = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        VERDICT_ICMP        = 3'd0,
        VERDICT_UDP         = 3'd1,
        VERDICT_UNSUPPORTED = 3'd2,
        VERDICT_TOO_SHORT   = 3'd3,
        VERDICT_MALFORMED   = 3'd4,
        VERDICT_BAD_CSUM    = 3'd5,
        VERDICT_FRAGMENTED  = 3'd6,
        VERDICT_NOT_LOCAL   = 3'd7
    } verdict_t;

    typedef struct packed {
        logic [15:0] byte_count;
        logic [3:0]  version;
        logic [5:0]  header_bytes;
        logic [15:0] tot_length;
        logic [15:0] running_sum;
        logic [15:0] checksum;
        logic [15:0] fragment_word;
        logic [7:0]  protocol;
        logic [31:0] source;
        logic [31:0] destination;
    } hdr_t;

    typedef struct packed {
        verdict_t    verdict;
        logic [7:0]  protocol_number;
        logic [31:0] source_address;
        logic [5:0]  payload_offset;
        logic [15:0] payload_length;
    } res_t;

    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        logic [15:0] r;
        s = {1'b0, a} + {1'b0, b};
        r = s[15:0] + {15'd0, s[16]};
        return r;
    endfunction

endpackage

@@ rtl/ipv4rhc_if.sv @@
// Request channel interfaces: packet bytes in, verdicts out.
// No dependencies.
interface ipv4rhc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ipv4rhc_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  verdict;
    logic [7:0]  protocol_number;
    logic [31:0] source_address;
    logic [5:0]  payload_offset;
    logic [15:0] payload_length;

    modport source (output valid, output verdict, output protocol_number,
                    output source_address, output payload_offset,
                    output payload_length, input ready);
    modport sink (input valid, input verdict, input protocol_number,
                  input source_address, input payload_offset,
                  input payload_length, output ready);
endinterface

@@ rtl/ipv4_receive_header_checker.sv @@
// Top level of the IPv4 receive header checker: input register, capture,
// verdict logic and result register. Depends on ipv4rhc_pkg, ipv4rhc_if,
// ipv4rhc_capture and ipv4rhc_verdict.
//
// Usage:
//   pkt carries one packet byte per request (data_byte, last_byte marks the
//   final byte). result carries one verdict per packet, produced only by the
//   last byte. local_address and address_valid are written through the
//   cfg_we / cfg_index / cfg_data port while the block is idle.
//   Throughput is one byte per clock, except while a last byte waits for the
//   result register. A byte sits in the input register and is folded into the
//   packet state at the edge that takes it out; a last byte loads its verdict
//   into the result register at the same edge, which raises result.valid.
//   The result register holds a verdict until the receiver takes it. While
//   it waits, bytes of the next packet keep flowing; only a further last
//   byte holds in the input register, and pkt.ready drops behind it.
//   Reset clears the configuration, all packet state and both valid flags.
module ipv4_receive_header_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    ipv4rhc_byte_if.sink                      pkt,
    ipv4rhc_result_if.source                  result,
    input  logic                              cfg_we,
    input  ipv4rhc_pkg::cfg_index_t           cfg_index,
    input  logic [ipv4rhc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ipv4rhc_pkg::*;

    logic [31:0] local_address_reg;
    logic        address_valid_reg;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [7:0]  s1_byte_reg;
    logic        s1_last_reg;
    logic        s1_adv;
    logic        pkt_fire;

    logic        res_valid_reg;
    logic        res_valid_next;
    res_t        res_reg;
    res_t        res_comb;
    hdr_t        hdr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_address_reg <= '0;
            address_valid_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LOCAL_ADDR: local_address_reg <= cfg_data[31:0];
                CFG_ADDR_VALID: address_valid_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // a last byte waits until the result register is free
    assign s1_adv    = s1_valid_reg && (!s1_last_reg || !res_valid_reg || result.ready);
    assign pkt.ready = !s1_valid_reg || s1_adv;
    assign pkt_fire  = pkt.valid && pkt.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (pkt_fire)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;

        res_valid_next = res_valid_reg;
        if (s1_adv && s1_last_reg)
            res_valid_next = 1'b1;
        else if (result.ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pkt_fire)
        begin
            s1_byte_reg <= pkt.data_byte;
            s1_last_reg <= pkt.last_byte;
        end
        if (s1_adv && s1_last_reg)
            res_reg <= res_comb;
    end

    ipv4rhc_capture u_capture (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (s1_adv),
        .data_byte (s1_byte_reg),
        .last_byte (s1_last_reg),
        .hdr       (hdr)
    );

    ipv4rhc_verdict u_verdict (
        .hdr           (hdr),
        .local_address (local_address_reg),
        .address_valid (address_valid_reg),
        .res           (res_comb)
    );

    assign result.valid           = res_valid_reg;
    assign result.verdict         = res_reg.verdict;
    assign result.protocol_number = res_reg.protocol_number;
    assign result.source_address  = res_reg.source_address;
    assign result.payload_offset  = res_reg.payload_offset;
    assign result.payload_length  = res_reg.payload_length;

`ifndef SYNTH
    a_last_makes_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && s1_last_reg |=> res_valid_reg)
        else $error("last byte did not produce a result");
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |-> !pkt.ready)
        else $error("input taken while held byte is stalled");
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |=> result.valid && $stable(res_reg))
        else $error("result changed while stalled");
`endif

endmodule

@@ rtl/ipv4rhc_capture.sv @@
// Per-packet state: byte count, header field capture and ones-complement sum.
// Depends on ipv4rhc_pkg.
module ipv4rhc_capture (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         data_byte,
    input  logic               last_byte,
    output ipv4rhc_pkg::hdr_t  hdr
);
    import ipv4rhc_pkg::*;

    hdr_t       state_reg;
    hdr_t       state_next;
    logic [7:0] pending_reg;
    logic [7:0] pending_next;
    logic [15:0] pos;
    logic [7:0] sum_byte;

    assign pos = state_reg.byte_count;

    always_comb
    begin
        state_next   = state_reg;
        pending_next = pending_reg;
        sum_byte     = (pos == POS_CSUM_HI || pos == POS_CSUM_LO) ? 8'd0 : data_byte;

        priority if (pos == POS_VER_IHL)
        begin
            state_next.version      = data_byte[7:4];
            state_next.header_bytes = {data_byte[3:0], 2'b00};
        end
        else if (pos == POS_TLEN_HI || pos == POS_TLEN_LO)
            state_next.tot_length = {state_reg.tot_length[7:0], data_byte};
        else if (pos == POS_FRAG_HI || pos == POS_FRAG_LO)
            state_next.fragment_word = {state_reg.fragment_word[7:0], data_byte};
        else if (pos == POS_PROTO)
            state_next.protocol = data_byte;
        else if (pos == POS_CSUM_HI || pos == POS_CSUM_LO)
            state_next.checksum = {state_reg.checksum[7:0], data_byte};
        else if (pos >= POS_SRC_FIRST && pos <= POS_SRC_LAST)
            state_next.source = {state_reg.source[23:0], data_byte};
        else if (pos >= POS_DST_FIRST && pos <= POS_DST_LAST)
            state_next.destination = {state_reg.destination[23:0], data_byte};
        else
            ;

        if (pos < {10'd0, state_next.header_bytes})
        begin
            if (!pos[0])
                pending_next = sum_byte;
            else
                state_next.running_sum = oc_add(state_reg.running_sum,
                                                {pending_reg, sum_byte});
        end

        if (pos != COUNT_MAX)
            state_next.byte_count = pos + 16'd1;
    end

    // next-state view feeds the verdict on the last byte
    assign hdr = state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= '0;
            pending_reg <= '0;
        end
        else if (step)
        begin
            if (last_byte)
            begin
                state_reg   <= '0;
                pending_reg <= '0;
            end
            else
            begin
                state_reg   <= state_next;
                pending_reg <= pending_next;
            end
        end
    end

`ifndef SYNTH
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        step && last_byte |=> state_reg.byte_count == 16'd0 && state_reg.running_sum == 16'd0)
        else $error("packet state not cleared after last byte");
    a_count_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        step && !last_byte && state_reg.byte_count == COUNT_MAX
        |=> state_reg.byte_count == COUNT_MAX)
        else $error("byte count wrapped");
    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(state_reg))
        else $error("packet state moved without a byte");
`endif

endmodule

@@ rtl/ipv4rhc_verdict.sv @@
// Ordered header checks producing one verdict and the result fields.
// Depends on ipv4rhc_pkg.
module ipv4rhc_verdict (
    input  ipv4rhc_pkg::hdr_t  hdr,
    input  logic [31:0]        local_address,
    input  logic               address_valid,
    output ipv4rhc_pkg::res_t  res
);
    import ipv4rhc_pkg::*;

    logic [15:0] ihl16;
    logic        malformed;
    logic        not_local;

    assign ihl16 = {10'd0, hdr.header_bytes};

    assign malformed = hdr.version != IPV4_VERSION || ihl16 < MIN_HDR_BYTES
                     || hdr.byte_count < ihl16 || hdr.tot_length < ihl16
                     || hdr.tot_length > hdr.byte_count;

    assign not_local = address_valid && hdr.destination != local_address
                     && hdr.destination != BCAST_ADDR;

    always_comb
    begin
        res.protocol_number = hdr.protocol;
        res.source_address  = hdr.source;
        res.payload_offset  = hdr.header_bytes;
        res.payload_length  = 16'd0;
        priority if (hdr.byte_count < MIN_HDR_BYTES)
            res.verdict = VERDICT_TOO_SHORT;
        else if (malformed)
            res.verdict = VERDICT_MALFORMED;
        else if (~hdr.running_sum != hdr.checksum)
            res.verdict = VERDICT_BAD_CSUM;
        else if ((hdr.fragment_word & FRAG_MASK) != 16'd0)
            res.verdict = VERDICT_FRAGMENTED;
        else if (not_local)
            res.verdict = VERDICT_NOT_LOCAL;
        else
        begin
            res.payload_length = hdr.tot_length - ihl16;
            priority if (hdr.protocol == PROTO_ICMP)
                res.verdict = VERDICT_ICMP;
            else if (hdr.protocol == PROTO_UDP)
                res.verdict = VERDICT_UDP;
            else
                res.verdict = VERDICT_UNSUPPORTED;
        end
    end

endmodule
